// ----- src/json_stream_tokenizer_top_assert.svh -----
// Assertion macros shared by the tokenizer checker.
`ifndef JSON_STREAM_TOKENIZER_TOP_ASSERT_SVH
`define JSON_STREAM_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define JST_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define JST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication that also holds across reset.
`define JST_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

// ----- src/jst_pkg.sv -----
// Package with the types, codes and character helpers of the JSON tokenizer.
`timescale 1ns / 1ps

package jst_pkg;

   typedef enum logic [2:0] {
      FR_START   = 3'd0,
      FR_ARRAY1  = 3'd1,
      FR_ARRAY2  = 3'd2,
      FR_OBJECT1 = 3'd3,
      FR_OBJECT2 = 3'd4,
      FR_OBJECT3 = 3'd5,
      FR_DONE    = 3'd6
   } frame_type;

   typedef enum logic [3:0] {
      MODE_STRUCT   = 4'd0,
      MODE_KEY      = 4'd1,
      MODE_KEY_ESC  = 4'd2,
      MODE_KEY_HEX  = 4'd3,
      MODE_COLON    = 4'd4,
      MODE_STR      = 4'd5,
      MODE_STR_ESC  = 4'd6,
      MODE_STR_HEX  = 4'd7,
      MODE_NUM      = 4'd8,
      MODE_KW_NULL  = 4'd9,
      MODE_KW_TRUE  = 4'd10,
      MODE_KW_FALSE = 4'd11
   } mode_type;

   typedef enum logic [1:0] {
      RUN_ACTIVE   = 2'd0,
      RUN_COMPLETE = 2'd1,
      RUN_ERROR    = 2'd2
   } run_type;

   typedef enum logic [3:0] {
      EV_START_ARRAY  = 4'd0,
      EV_END_ARRAY    = 4'd1,
      EV_START_OBJECT = 4'd2,
      EV_END_OBJECT   = 4'd3,
      EV_KEY_CHAR     = 4'd4,
      EV_KEY_END      = 4'd5,
      EV_STR_CHAR     = 4'd6,
      EV_STR_END      = 4'd7,
      EV_NUM_CHAR     = 4'd8,
      EV_NUM_END      = 4'd9,
      EV_NULL         = 4'd10,
      EV_TRUE         = 4'd11,
      EV_FALSE        = 4'd12,
      EV_EOS          = 4'd13,
      EV_ERROR        = 4'd14
   } ev_kind_type;

   typedef enum logic [3:0] {
      ERR_NONE         = 4'd0,
      ERR_VALUE_START  = 4'd1,
      ERR_ARRAY_SEP    = 4'd2,
      ERR_KEY_START    = 4'd3,
      ERR_COLON        = 4'd4,
      ERR_OBJECT_SEP   = 4'd5,
      ERR_END_IN_STR   = 4'd6,
      ERR_HEX_DIGIT    = 4'd7,
      ERR_UNICODE      = 4'd8,
      ERR_END_IN_NUM   = 4'd9,
      ERR_NUM_NO_DIGIT = 4'd10,
      ERR_UNEXP_END    = 4'd11,
      ERR_DEPTH        = 4'd12
   } err_type;

   // One result beat as it sits in the result queue.
   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  chr;
      err_type     err;
      logic [5:0]  level;
      logic        last;
   } res_type;

   // What one accepted input beat produces.
   typedef struct packed {
      logic [1:0] cnt;
      res_type    res0;
      res_type    res1;
   } step_type;

   function automatic logic is_ws(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [7:0] unescape(logic [7:0] c);
      logic [7:0] r;
      case (c)
         "b":     r = 8'd8;
         "f":     r = 8'd12;
         "n":     r = 8'd10;
         "r":     r = 8'd13;
         "t":     r = 8'd9;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] kw_len(mode_type m);
      return (m == MODE_KW_FALSE) ? 3'd5 : 3'd4;
   endfunction

   function automatic logic [7:0] kw_char(mode_type m, logic [2:0] idx);
      logic [7:0] r;
      r = 8'h00;
      if (m == MODE_KW_NULL) begin
         case (idx)
            3'd0:    r = "n";
            3'd1:    r = "u";
            3'd2:    r = "l";
            3'd3:    r = "l";
            default: r = 8'h00;
         endcase
      end else if (m == MODE_KW_TRUE) begin
         case (idx)
            3'd0:    r = "t";
            3'd1:    r = "r";
            3'd2:    r = "u";
            3'd3:    r = "e";
            default: r = 8'h00;
         endcase
      end else begin
         case (idx)
            3'd0:    r = "f";
            3'd1:    r = "a";
            3'd2:    r = "l";
            3'd3:    r = "s";
            3'd4:    r = "e";
            default: r = 8'h00;
         endcase
      end
      return r;
   endfunction

endpackage

// ----- src/jst_if.sv -----
// Channel interfaces of the JSON tokenizer: input bytes and result events.
`timescale 1ns / 1ps

interface jst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, data_byte, end_of_input, input ready);
   modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

interface jst_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_kind;
   logic [7:0] event_byte;
   logic [3:0] error_code;
   logic [5:0] nesting_level;
   logic       last_of_run;

   modport source (output valid, event_kind, event_byte, error_code, nesting_level,
                   last_of_run, input ready);
   modport sink (input valid, event_kind, event_byte, error_code, nesting_level,
                 last_of_run, output ready);
endinterface

// ----- src/json_stream_tokenizer_top.sv -----
// Top level of the streaming JSON tokenizer.
//
//   Channel   Direction  Beat carries
//   req_ch    in         data_byte, end_of_input
//   rsp_ch    out        event_kind, event_byte, error_code, nesting_level, last_of_run
//
// One input beat is taken per clock while the queue has room. The whole parse
// step for a byte is done in the same cycle the beat is accepted, from the
// parser registers, and its events, at most two, are written into a four-entry
// result queue. Results appear on rsp_ch in the cycle after the input beat
// at the earliest. The input is ready while the queue has room for two events,
// so while rsp_ch is ready a run of single-event bytes flows at one beat per
// clock; a byte with two events waits longer, as the single result port sends one event at a time.
// Reset is synchronous and active high; there is no clearing pass. A stall on
// rsp_ch fills the queue and then drops req_ch.ready.
`timescale 1ns / 1ps

module json_stream_tokenizer_top #(
   parameter int MAX_DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   jst_req_if.sink   req_ch,
   jst_rsp_if.source rsp_ch
);

   jst_pkg::step_type step;
   jst_pkg::res_type  out_res;
   logic              room;
   logic              accept;

   // A beat is accepted only while the queue can take everything it causes.
   assign req_ch.ready = room;
   assign accept       = req_ch.valid && room;

   jst_core #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_ch.data_byte),
      .end_of_input (req_ch.end_of_input),
      .step         (step)
   );

   jst_res_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .room      (room),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_res   (out_res)
   );

   // Unpack the queued event onto the result channel.
   assign rsp_ch.event_kind    = out_res.kind;
   assign rsp_ch.event_byte    = out_res.chr;
   assign rsp_ch.error_code    = out_res.err;
   assign rsp_ch.nesting_level = out_res.level;
   assign rsp_ch.last_of_run   = out_res.last;

endmodule

// ----- src/jst_core.sv -----
// Parser state registers and the combinational step logic for one input byte.
`timescale 1ns / 1ps

module jst_core #(
   parameter int MAX_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              end_of_input,
   output jst_pkg::step_type step
);

   localparam int TOP_W = $clog2(MAX_DEPTH);
   localparam int STK_W = MAX_DEPTH - 1;
   localparam logic [TOP_W-1:0] TOP_MAX = TOP_W'(MAX_DEPTH - 1);

   // The frame under the current one is always "array after element" or
   // "object after value", so each parent entry is one bit: 1 for object.
   typedef struct packed {
      jst_pkg::mode_type  mode;
      jst_pkg::frame_type frame;
      logic [TOP_W-1:0]   top;
      logic [STK_W-1:0]   stk;
      logic [2:0]         kwp;
      logic [2:0]         hexc;
      logic               hasd;
      jst_pkg::run_type   run;
      logic [1:0]         cnt;
      jst_pkg::res_type   res0;
      jst_pkg::res_type   res1;
   } ctx_type;

   jst_pkg::mode_type  mode_ff, mode_in;
   jst_pkg::frame_type frame_ff, frame_in;
   logic [TOP_W-1:0]   top_ff, top_in;
   logic [STK_W-1:0]   stk_ff, stk_in;
   logic [2:0]         kwp_ff, kwp_in;
   logic [2:0]         hexc_ff, hexc_in;
   logic               hasd_ff, hasd_in;
   jst_pkg::run_type   run_ff, run_in;

   function automatic ctx_type f_emit(ctx_type c, jst_pkg::ev_kind_type k,
                                      logic [7:0] ch, jst_pkg::err_type e);
      jst_pkg::res_type r;
      r.kind  = k;
      r.chr   = ch;
      r.err   = e;
      r.level = 6'(c.top);
      r.last  = 1'b0;
      if (c.cnt == 2'd0) begin
         c.res0 = r;
         c.cnt  = 2'd1;
      end else if (c.cnt == 2'd1) begin
         c.res1 = r;
         c.cnt  = 2'd2;
      end
      return c;
   endfunction

   function automatic ctx_type f_raise(ctx_type c, jst_pkg::err_type e);
      c.run = jst_pkg::RUN_ERROR;
      return f_emit(c, jst_pkg::EV_ERROR, 8'h00, e);
   endfunction

   function automatic ctx_type f_close(ctx_type c, jst_pkg::ev_kind_type k);
      if (c.top == '0) begin
         c.frame = jst_pkg::FR_DONE;
         c.run   = jst_pkg::RUN_COMPLETE;
      end else begin
         c.frame = c.stk[0] ? jst_pkg::FR_OBJECT3 : jst_pkg::FR_ARRAY2;
         c.stk   = c.stk >> 1;
         c.top   = c.top - 1'b1;
      end
      return f_emit(c, k, 8'h00, jst_pkg::ERR_NONE);
   endfunction

   function automatic ctx_type f_push(ctx_type c, logic obj);
      c.stk   = (c.stk << 1) | STK_W'(obj);
      c.top   = c.top + 1'b1;
      c.frame = jst_pkg::FR_START;
      return c;
   endfunction

   function automatic ctx_type f_start_value(ctx_type c, logic [7:0] ch);
      if (ch == "[") begin
         c.frame = jst_pkg::FR_ARRAY1;
         c = f_emit(c, jst_pkg::EV_START_ARRAY, 8'h00, jst_pkg::ERR_NONE);
      end else if (ch == "{") begin
         c.frame = jst_pkg::FR_OBJECT1;
         c = f_emit(c, jst_pkg::EV_START_OBJECT, 8'h00, jst_pkg::ERR_NONE);
      end else if (ch == "\"") begin
         c.mode = jst_pkg::MODE_STR;
      end else if (ch == "n" || ch == "t" || ch == "f") begin
         c.mode = (ch == "n") ? jst_pkg::MODE_KW_NULL :
                  (ch == "t") ? jst_pkg::MODE_KW_TRUE : jst_pkg::MODE_KW_FALSE;
         c.kwp  = 3'd1;
      end else if (ch == "-" || jst_pkg::is_digit(ch)) begin
         c.mode = jst_pkg::MODE_NUM;
         c.hasd = jst_pkg::is_digit(ch);
         c = f_emit(c, jst_pkg::EV_NUM_CHAR, ch, jst_pkg::ERR_NONE);
      end else begin
         c = f_raise(c, jst_pkg::ERR_VALUE_START);
      end
      return c;
   endfunction

   function automatic ctx_type f_structural(ctx_type c, logic [7:0] ch);
      if (c.run == jst_pkg::RUN_ACTIVE && !jst_pkg::is_ws(ch)) begin
         case (c.frame)
            jst_pkg::FR_START: c = f_start_value(c, ch);
            jst_pkg::FR_ARRAY1: begin
               if (ch == "]") begin
                  c = f_close(c, jst_pkg::EV_END_ARRAY);
               end else if (c.top == TOP_MAX) begin
                  c = f_raise(c, jst_pkg::ERR_DEPTH);
               end else begin
                  c = f_start_value(f_push(c, 1'b0), ch);
               end
            end
            jst_pkg::FR_ARRAY2: begin
               if (ch == "]") begin
                  c = f_close(c, jst_pkg::EV_END_ARRAY);
               end else if (ch == ",") begin
                  if (c.top == TOP_MAX) c = f_raise(c, jst_pkg::ERR_DEPTH);
                  else c = f_push(c, 1'b0);
               end else begin
                  c = f_raise(c, jst_pkg::ERR_ARRAY_SEP);
               end
            end
            jst_pkg::FR_OBJECT1: begin
               if (ch == "}") c = f_close(c, jst_pkg::EV_END_OBJECT);
               else if (ch == "\"") c.mode = jst_pkg::MODE_KEY;
               else c = f_raise(c, jst_pkg::ERR_KEY_START);
            end
            jst_pkg::FR_OBJECT2: begin
               if (ch == "}") begin
                  c = f_close(c, jst_pkg::EV_END_OBJECT);
               end else if (c.top == TOP_MAX) begin
                  c = f_raise(c, jst_pkg::ERR_DEPTH);
               end else begin
                  c = f_start_value(f_push(c, 1'b1), ch);
               end
            end
            jst_pkg::FR_OBJECT3: begin
               if (ch == "}") c = f_close(c, jst_pkg::EV_END_OBJECT);
               else if (ch == ",") c.frame = jst_pkg::FR_OBJECT1;
               else c = f_raise(c, jst_pkg::ERR_OBJECT_SEP);
            end
            default: c = c;
         endcase
      end
      return c;
   endfunction

   function automatic ctx_type f_text(ctx_type c, logic [7:0] ch);
      logic                 key;
      jst_pkg::ev_kind_type ck;
      key = c.mode == jst_pkg::MODE_KEY || c.mode == jst_pkg::MODE_KEY_ESC ||
            c.mode == jst_pkg::MODE_KEY_HEX;
      ck  = key ? jst_pkg::EV_KEY_CHAR : jst_pkg::EV_STR_CHAR;
      if (c.mode == jst_pkg::MODE_KEY || c.mode == jst_pkg::MODE_STR) begin
         if (ch == "\"") begin
            if (key) begin
               c.mode = jst_pkg::MODE_COLON;
               c = f_emit(c, jst_pkg::EV_KEY_END, 8'h00, jst_pkg::ERR_NONE);
            end else begin
               c.mode = jst_pkg::MODE_STRUCT;
               c = f_close(c, jst_pkg::EV_STR_END);
            end
         end else if (ch == "\\") begin
            c.mode = key ? jst_pkg::MODE_KEY_ESC : jst_pkg::MODE_STR_ESC;
         end else begin
            c = f_emit(c, ck, ch, jst_pkg::ERR_NONE);
         end
      end else if (c.mode == jst_pkg::MODE_KEY_ESC || c.mode == jst_pkg::MODE_STR_ESC) begin
         if (ch == "u") begin
            c.mode = key ? jst_pkg::MODE_KEY_HEX : jst_pkg::MODE_STR_HEX;
            c.hexc = 3'd0;
         end else begin
            c.mode = key ? jst_pkg::MODE_KEY : jst_pkg::MODE_STR;
            c = f_emit(c, ck, jst_pkg::unescape(ch), jst_pkg::ERR_NONE);
         end
      end else if (!jst_pkg::is_hex(ch)) begin
         c = f_raise(c, jst_pkg::ERR_HEX_DIGIT);
      end else begin
         c.hexc = c.hexc + 3'd1;
         if (c.hexc >= 3'd4) c = f_raise(c, jst_pkg::ERR_UNICODE);
      end
      return c;
   endfunction

   function automatic ctx_type f_keyword(ctx_type c, logic [7:0] ch);
      logic [2:0]           len;
      jst_pkg::ev_kind_type k;
      len = jst_pkg::kw_len(c.mode);
      k   = (c.mode == jst_pkg::MODE_KW_NULL) ? jst_pkg::EV_NULL :
            (c.mode == jst_pkg::MODE_KW_TRUE) ? jst_pkg::EV_TRUE : jst_pkg::EV_FALSE;
      if (c.kwp >= len || ch != jst_pkg::kw_char(c.mode, c.kwp)) begin
         c = f_raise(c, jst_pkg::ERR_VALUE_START);
      end else begin
         c.kwp = c.kwp + 3'd1;
         if (c.kwp == len) begin
            c.mode = jst_pkg::MODE_STRUCT;
            c.kwp  = 3'd0;
            c = f_close(c, k);
         end
      end
      return c;
   endfunction

   function automatic ctx_type f_number(ctx_type c, logic [7:0] ch);
      if (jst_pkg::is_digit(ch)) begin
         c.hasd = 1'b1;
         c = f_emit(c, jst_pkg::EV_NUM_CHAR, ch, jst_pkg::ERR_NONE);
      end else if (ch == "-" || ch == "." || ch == "e" || ch == "E") begin
         c = f_emit(c, jst_pkg::EV_NUM_CHAR, ch, jst_pkg::ERR_NONE);
      end else if (!c.hasd) begin
         c = f_raise(c, jst_pkg::ERR_NUM_NO_DIGIT);
      end else begin
         c.mode = jst_pkg::MODE_STRUCT;
         c.hasd = 1'b0;
         c = f_structural(f_close(c, jst_pkg::EV_NUM_END), ch);
      end
      return c;
   endfunction

   function automatic ctx_type f_end(ctx_type c);
      if (c.run == jst_pkg::RUN_COMPLETE) begin
         c = f_emit(c, jst_pkg::EV_EOS, 8'h00, jst_pkg::ERR_NONE);
      end else if (c.run == jst_pkg::RUN_ACTIVE) begin
         case (c.mode) inside
            jst_pkg::MODE_KEY, jst_pkg::MODE_KEY_ESC, jst_pkg::MODE_KEY_HEX,
            jst_pkg::MODE_STR, jst_pkg::MODE_STR_ESC, jst_pkg::MODE_STR_HEX:
               c = f_raise(c, jst_pkg::ERR_END_IN_STR);
            jst_pkg::MODE_NUM: c = f_raise(c, jst_pkg::ERR_END_IN_NUM);
            default:           c = f_raise(c, jst_pkg::ERR_UNEXP_END);
         endcase
      end
      return c;
   endfunction

   ctx_type cx;

   always_comb begin
      cx       = '0;
      cx.mode  = mode_ff;
      cx.frame = frame_ff;
      cx.top   = top_ff;
      cx.stk   = stk_ff;
      cx.kwp   = kwp_ff;
      cx.hexc  = hexc_ff;
      cx.hasd  = hasd_ff;
      cx.run   = run_ff;
      if (end_of_input) begin
         cx = f_end(cx);
      end else if (run_ff == jst_pkg::RUN_ACTIVE) begin
         case (mode_ff) inside
            jst_pkg::MODE_STRUCT: cx = f_structural(cx, data_byte);
            jst_pkg::MODE_COLON: begin
               if (data_byte == ":") begin
                  cx.frame = jst_pkg::FR_OBJECT2;
                  cx.mode  = jst_pkg::MODE_STRUCT;
               end else if (!jst_pkg::is_ws(data_byte)) begin
                  cx = f_raise(cx, jst_pkg::ERR_COLON);
               end
            end
            jst_pkg::MODE_NUM: cx = f_number(cx, data_byte);
            jst_pkg::MODE_KW_NULL, jst_pkg::MODE_KW_TRUE, jst_pkg::MODE_KW_FALSE:
               cx = f_keyword(cx, data_byte);
            default: cx = f_text(cx, data_byte);
         endcase
      end
      if (cx.cnt == 2'd1) cx.res0.last = 1'b1;
      if (cx.cnt == 2'd2) cx.res1.last = 1'b1;

      mode_in  = accept ? cx.mode  : mode_ff;
      frame_in = accept ? cx.frame : frame_ff;
      top_in   = accept ? cx.top   : top_ff;
      stk_in   = accept ? cx.stk   : stk_ff;
      kwp_in   = accept ? cx.kwp   : kwp_ff;
      hexc_in  = accept ? cx.hexc  : hexc_ff;
      hasd_in  = accept ? cx.hasd  : hasd_ff;
      run_in   = accept ? cx.run   : run_ff;

      step.cnt  = accept ? cx.cnt : 2'd0;
      step.res0 = cx.res0;
      step.res1 = cx.res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= jst_pkg::MODE_STRUCT;
         frame_ff <= jst_pkg::FR_START;
         top_ff   <= '0;
         stk_ff   <= '0;
         kwp_ff   <= 3'd0;
         hexc_ff  <= 3'd0;
         hasd_ff  <= 1'b0;
         run_ff   <= jst_pkg::RUN_ACTIVE;
      end else begin
         mode_ff  <= mode_in;
         frame_ff <= frame_in;
         top_ff   <= top_in;
         stk_ff   <= stk_in;
         kwp_ff   <= kwp_in;
         hexc_ff  <= hexc_in;
         hasd_ff  <= hasd_in;
         run_ff   <= run_in;
      end
   end

endmodule

// ----- src/jst_res_queue.sv -----
// Four-entry result queue that takes up to two events a cycle and sends one.
`timescale 1ns / 1ps

module jst_res_queue (
   input  logic              clock,
   input  logic              reset,
   input  jst_pkg::step_type step,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output jst_pkg::res_type  out_res
);

   jst_pkg::res_type mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign out_valid = count_ff != 3'd0;
   assign out_res   = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // Room for the worst case of two events from the next beat.
   assign room      = count_ff <= 3'd2;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + step.cnt;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, step.cnt} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (step.cnt != 2'd0) mem_ff[wr_ptr_ff] <= step.res0;
      if (step.cnt == 2'd2) mem_ff[wr_ptr_ff + 2'd1] <= step.res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/jst_checker.sv -----
// Port-level checker for the JSON tokenizer and its bind to the top level.
`timescale 1ns / 1ps
`include "json_stream_tokenizer_top_assert.svh"

module jst_checker #(
   parameter int MAX_DEPTH = 32
) (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] event_kind,
   input logic [3:0] error_code,
   input logic [5:0] nesting_level,
   input logic       last_of_run
);

   localparam logic [8:0] LEVEL_MAX = 9'(MAX_DEPTH - 1);

   logic is_error_ev;
   logic has_code;

   assign is_error_ev = event_kind == jst_pkg::EV_ERROR;
   assign has_code    = error_code != jst_pkg::ERR_NONE;

   // A stalled result beat stays offered.
   `JST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // Only error events carry an error code, and they always do.
   `JST_ASSERT_NOW(a_err_code, clock, reset, rsp_valid, is_error_ev == has_code)

   // Errors are final: an error event closes its run and nothing follows it.
   `JST_ASSERT_NOW(a_err_last, clock, reset, rsp_valid && is_error_ev, last_of_run)

   // The reported depth never exceeds the stack.
   `JST_ASSERT_NOW(a_level, clock, reset, rsp_valid, {3'b000, nesting_level} <= LEVEL_MAX)

   // Reset empties the result queue.
   `JST_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind json_stream_tokenizer_top jst_checker #(
   .MAX_DEPTH (MAX_DEPTH)
) u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .event_kind    (rsp_ch.event_kind),
   .error_code    (rsp_ch.error_code),
   .nesting_level (rsp_ch.nesting_level),
   .last_of_run   (rsp_ch.last_of_run)
);

// ----- tb/json_stream_tokenizer_top_tb.sv -----
// Self-checking testbench for the streaming JSON tokenizer.
`timescale 1ns / 1ps

module json_stream_tokenizer_top_tb;

   localparam int DEPTH_LIMIT = 32;
   localparam int STALL_LIMIT = 2000;

   // One expected result event, at the widths of the result channel.
   typedef struct {
      jst_pkg::ev_kind_type kind;
      logic [7:0]           chr;
      jst_pkg::err_type     err;
      logic [5:0]           level;
      logic                 last;
   } exp_event_type;

   // One row of the directed table. When check_kind is set, the first event
   // that the row causes must also match the kind and error typed in here,
   // on top of the predictor check.
   typedef struct {
      logic                 eoi;
      logic [7:0]           chr;
      logic                 check_kind;
      jst_pkg::ev_kind_type kind;
      jst_pkg::err_type     err;
   } dir_row_type;

   logic clock;
   logic reset;

   jst_req_if req_ch ();
   jst_rsp_if rsp_ch ();

   json_stream_tokenizer_top #(.MAX_DEPTH(DEPTH_LIMIT)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   // The tokenizer state as the predictor sees it.
   jst_pkg::frame_type frames [DEPTH_LIMIT];
   int unsigned        top_idx;
   jst_pkg::mode_type  lex_mode;
   int unsigned        kw_pos;
   int unsigned        hex_seen;
   bit                 num_digit;
   jst_pkg::run_type   run_state;

   // Events still to arrive, oldest first, and what this beat produced.
   exp_event_type expected_events[$];
   exp_event_type step_events[$];

   int fail_count;
   int table_fails;
   int events_seen;
   int beats_sent;
   int texts_sent;
   int errors_seen;
   int idle_cycles;
   int rx_hold;
   bit timed_out;

   // Clock; the bench applies a single reset at the start of the run.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor. Every routine below changes the mirror state in the same
   // order as the tokenizer, and appends the events of one beat to
   // step_events. At most two events can come out of one beat.
   // ------------------------------------------------------------------------
   function automatic void add_event(jst_pkg::ev_kind_type k, logic [7:0] c,
                                     jst_pkg::err_type e);
      exp_event_type r;
      if (step_events.size() >= 2) return;
      r.kind  = k;
      r.chr   = c;
      r.err   = e;
      r.level = top_idx[5:0];
      r.last  = 1'b0;
      step_events.insert(step_events.size(), r);
   endfunction

   function automatic void flag_error(jst_pkg::err_type e);
      run_state = jst_pkg::RUN_ERROR;
      add_event(jst_pkg::EV_ERROR, 8'h00, e);
   endfunction

   function automatic bit ws_char(logic [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D;
   endfunction

   function automatic bit dec_char(logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit hex_char(logic [7:0] c);
      return dec_char(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   // A finished value marks its frame done and pops back to the parent, or
   // completes the whole text when it was the top-level value.
   function automatic void finish_value(jst_pkg::ev_kind_type k);
      frames[top_idx] = jst_pkg::FR_DONE;
      if (top_idx == 0) run_state = jst_pkg::RUN_COMPLETE;
      else top_idx--;
      add_event(k, 8'h00, jst_pkg::ERR_NONE);
   endfunction

   function automatic bit open_child(jst_pkg::frame_type parent);
      if (top_idx + 1 >= DEPTH_LIMIT) begin
         flag_error(jst_pkg::ERR_DEPTH);
         return 1'b0;
      end
      frames[top_idx] = parent;
      top_idx++;
      frames[top_idx] = jst_pkg::FR_START;
      return 1'b1;
   endfunction

   function automatic void begin_value(logic [7:0] c);
      if (c == "[") begin
         frames[top_idx] = jst_pkg::FR_ARRAY1;
         add_event(jst_pkg::EV_START_ARRAY, 8'h00, jst_pkg::ERR_NONE);
      end else if (c == "{") begin
         frames[top_idx] = jst_pkg::FR_OBJECT1;
         add_event(jst_pkg::EV_START_OBJECT, 8'h00, jst_pkg::ERR_NONE);
      end else if (c == 8'h22) begin
         lex_mode = jst_pkg::MODE_STR;
      end else if (c == "n" || c == "t" || c == "f") begin
         lex_mode = (c == "n") ? jst_pkg::MODE_KW_NULL :
                    (c == "t") ? jst_pkg::MODE_KW_TRUE : jst_pkg::MODE_KW_FALSE;
         kw_pos = 1;
      end else if (c == "-" || dec_char(c)) begin
         lex_mode  = jst_pkg::MODE_NUM;
         num_digit = dec_char(c);
         add_event(jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
      end else begin
         flag_error(jst_pkg::ERR_VALUE_START);
      end
   endfunction

   // Structure byte. An element or member value that follows directly opens
   // a child frame and is then handled again as a value start.
   function automatic void struct_byte(logic [7:0] c);
      if (run_state != jst_pkg::RUN_ACTIVE || ws_char(c)) return;
      forever begin
         case (frames[top_idx])
            jst_pkg::FR_START: begin
               begin_value(c);
               return;
            end
            jst_pkg::FR_ARRAY1: begin
               if (c == "]") begin
                  finish_value(jst_pkg::EV_END_ARRAY);
                  return;
               end
               if (!open_child(jst_pkg::FR_ARRAY2)) return;
            end
            jst_pkg::FR_ARRAY2: begin
               if (c == "]") finish_value(jst_pkg::EV_END_ARRAY);
               else if (c == ",") void'(open_child(jst_pkg::FR_ARRAY2));
               else flag_error(jst_pkg::ERR_ARRAY_SEP);
               return;
            end
            jst_pkg::FR_OBJECT1: begin
               if (c == "}") finish_value(jst_pkg::EV_END_OBJECT);
               else if (c == 8'h22) lex_mode = jst_pkg::MODE_KEY;
               else flag_error(jst_pkg::ERR_KEY_START);
               return;
            end
            jst_pkg::FR_OBJECT2: begin
               if (c == "}") begin
                  finish_value(jst_pkg::EV_END_OBJECT);
                  return;
               end
               if (!open_child(jst_pkg::FR_OBJECT3)) return;
            end
            jst_pkg::FR_OBJECT3: begin
               if (c == "}") finish_value(jst_pkg::EV_END_OBJECT);
               else if (c == ",") frames[top_idx] = jst_pkg::FR_OBJECT1;
               else flag_error(jst_pkg::ERR_OBJECT_SEP);
               return;
            end
            default: return;
         endcase
      end
   endfunction

   function automatic logic [7:0] decode_escape(logic [7:0] c);
      case (c)
         "b":     return 8'd8;
         "f":     return 8'd12;
         "n":     return 8'd10;
         "r":     return 8'd13;
         "t":     return 8'd9;
         default: return c;
      endcase
   endfunction

   // Bytes inside a key or a string, including escapes and unicode digits.
   function automatic void quoted_byte(logic [7:0] c);
      bit                   in_key;
      jst_pkg::ev_kind_type ch_kind;
      in_key  = lex_mode inside {jst_pkg::MODE_KEY, jst_pkg::MODE_KEY_ESC,
                                 jst_pkg::MODE_KEY_HEX};
      ch_kind = in_key ? jst_pkg::EV_KEY_CHAR : jst_pkg::EV_STR_CHAR;
      if (lex_mode == jst_pkg::MODE_KEY || lex_mode == jst_pkg::MODE_STR) begin
         if (c == 8'h22) begin
            if (in_key) begin
               lex_mode = jst_pkg::MODE_COLON;
               add_event(jst_pkg::EV_KEY_END, 8'h00, jst_pkg::ERR_NONE);
            end else begin
               lex_mode = jst_pkg::MODE_STRUCT;
               finish_value(jst_pkg::EV_STR_END);
            end
         end else if (c == 8'h5C) begin
            lex_mode = in_key ? jst_pkg::MODE_KEY_ESC : jst_pkg::MODE_STR_ESC;
         end else begin
            add_event(ch_kind, c, jst_pkg::ERR_NONE);
         end
      end else if (lex_mode == jst_pkg::MODE_KEY_ESC || lex_mode == jst_pkg::MODE_STR_ESC) begin
         if (c == "u") begin
            lex_mode = in_key ? jst_pkg::MODE_KEY_HEX : jst_pkg::MODE_STR_HEX;
            hex_seen = 0;
         end else begin
            lex_mode = in_key ? jst_pkg::MODE_KEY : jst_pkg::MODE_STR;
            add_event(ch_kind, decode_escape(c), jst_pkg::ERR_NONE);
         end
      end else begin
         if (!hex_char(c)) begin
            flag_error(jst_pkg::ERR_HEX_DIGIT);
            return;
         end
         hex_seen = (hex_seen + 1) & 7;
         if (hex_seen >= 4) flag_error(jst_pkg::ERR_UNICODE);
      end
   endfunction

   function automatic void word_byte(logic [7:0] c);
      string                word;
      jst_pkg::ev_kind_type k;
      case (lex_mode)
         jst_pkg::MODE_KW_NULL: begin word = "null";  k = jst_pkg::EV_NULL; end
         jst_pkg::MODE_KW_TRUE: begin word = "true";  k = jst_pkg::EV_TRUE; end
         default:               begin word = "false"; k = jst_pkg::EV_FALSE; end
      endcase
      if (kw_pos >= word.len() || c != word[kw_pos]) begin
         flag_error(jst_pkg::ERR_VALUE_START);
         return;
      end
      kw_pos++;
      if (kw_pos == word.len()) begin
         lex_mode = jst_pkg::MODE_STRUCT;
         kw_pos   = 0;
         finish_value(k);
      end
   endfunction

   // A number closes on the first byte that cannot extend it; that byte is
   // then handled as structure in the same beat, so two events can result.
   function automatic void number_part(logic [7:0] c);
      if (dec_char(c)) begin
         num_digit = 1'b1;
         add_event(jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
      end else if (c == "-" || c == "." || c == "e" || c == "E") begin
         add_event(jst_pkg::EV_NUM_CHAR, c, jst_pkg::ERR_NONE);
      end else if (!num_digit) begin
         flag_error(jst_pkg::ERR_NUM_NO_DIGIT);
      end else begin
         lex_mode  = jst_pkg::MODE_STRUCT;
         num_digit = 1'b0;
         finish_value(jst_pkg::EV_NUM_END);
         struct_byte(c);
      end
   endfunction

   function automatic void text_end();
      if (run_state == jst_pkg::RUN_COMPLETE) begin
         add_event(jst_pkg::EV_EOS, 8'h00, jst_pkg::ERR_NONE);
         return;
      end
      if (run_state != jst_pkg::RUN_ACTIVE) return;
      if (lex_mode inside {jst_pkg::MODE_KEY, jst_pkg::MODE_KEY_ESC, jst_pkg::MODE_KEY_HEX,
                           jst_pkg::MODE_STR, jst_pkg::MODE_STR_ESC, jst_pkg::MODE_STR_HEX})
         flag_error(jst_pkg::ERR_END_IN_STR);
      else if (lex_mode == jst_pkg::MODE_NUM)
         flag_error(jst_pkg::ERR_END_IN_NUM);
      else
         flag_error(jst_pkg::ERR_UNEXP_END);
   endfunction

   function automatic void clear_parser();
      foreach (frames[i]) frames[i] = jst_pkg::FR_START;
      top_idx   = 0;
      lex_mode  = jst_pkg::MODE_STRUCT;
      kw_pos    = 0;
      hex_seen  = 0;
      num_digit = 1'b0;
      run_state = jst_pkg::RUN_ACTIVE;
   endfunction

   // Runs one accepted beat through the predictor and queues its events.
   function automatic void predict_events(logic eoi, logic [7:0] c);
      step_events.delete();
      if (eoi) text_end();
      else if (run_state == jst_pkg::RUN_ACTIVE) begin
         case (lex_mode)
            jst_pkg::MODE_STRUCT: struct_byte(c);
            jst_pkg::MODE_COLON: begin
               if (!ws_char(c)) begin
                  if (c == ":") begin
                     frames[top_idx] = jst_pkg::FR_OBJECT2;
                     lex_mode = jst_pkg::MODE_STRUCT;
                  end else begin
                     flag_error(jst_pkg::ERR_COLON);
                  end
               end
            end
            jst_pkg::MODE_NUM: number_part(c);
            jst_pkg::MODE_KW_NULL, jst_pkg::MODE_KW_TRUE, jst_pkg::MODE_KW_FALSE:
               word_byte(c);
            default: quoted_byte(c);
         endcase
      end
      if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
      foreach (step_events[i]) expected_events.insert(expected_events.size(), step_events[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Sender side. Beats are driven with nonblocking assignments right after
   // the rising edge; the beat is taken at the first edge where ready is high.
   // The mirror is updated at that same edge, so expectations always lead the
   // result beats that they describe. Valid stays high into the next beat
   // when there is no gap, and is dropped only when the sender pauses.
   // ------------------------------------------------------------------------
   task automatic send_beat(logic eoi, logic [7:0] c);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= c;
      req_ch.end_of_input <= eoi;
      do @(posedge clock); while (!req_ch.ready);
      predict_events(eoi, c);
      beats_sent++;
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
   endtask

   // Stops offering beats and waits until every expected event has come.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0 && !timed_out) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: after each beat it holds ready low for a randomly drawn hold,
   // possibly none, and it checks every beat field by field.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rx_side
      exp_event_type e;
      int            hold;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rx_hold      <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected event kind %0d byte %0h", $time,
                        rsp_ch.event_kind, rsp_ch.event_byte);
            end else begin
               e = expected_events.pop_front();
               if (rsp_ch.event_kind !== e.kind || rsp_ch.event_byte !== e.chr ||
                   rsp_ch.error_code !== e.err || rsp_ch.nesting_level !== e.level ||
                   rsp_ch.last_of_run !== e.last) begin
                  fail_count++;
                  $display("%0t: expected kind %0d byte %0h err %0d level %0d last %0b",
                           $time, e.kind, e.chr, e.err, e.level, e.last);
                  $display("%0t: actual   kind %0d byte %0h err %0d level %0d last %0b",
                           $time, rsp_ch.event_kind, rsp_ch.event_byte,
                           rsp_ch.error_code, rsp_ch.nesting_level, rsp_ch.last_of_run);
               end
               if (e.kind == jst_pkg::EV_ERROR) errors_seen++;
            end
            hold = $urandom_range(0, 7);
            rx_hold      <= hold;
            rsp_ch.ready <= (hold == 0);
         end else if (rx_hold != 0) begin
            rx_hold      <= rx_hold - 1;
            rsp_ch.ready <= (rx_hold == 1);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Random text generation: values that the block accepts, with random content.
   // Errors are left for the end of the run, since they are sticky.
   // ------------------------------------------------------------------------
   function automatic string char_str(logic [7:0] c);
      string s;
      s = " ";
      s.putc(0, c);
      return s;
   endfunction

   function automatic string rand_plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(32, 255));
      if (c == 8'h22 || c == 8'h5C) c = "a";
      return char_str(c);
   endfunction

   function automatic string rand_string_body();
      string s;
      string esc;
      int    n;
      s   = "";
      esc = "bfnrt/\\\"";
      n   = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 5))
            0:       s = {s, "\\", char_str(esc[$urandom_range(0, 7)])};
            default: s = {s, rand_plain_char()};
         endcase
      end
      return s;
   endfunction

   function automatic string rand_number();
      string s;
      string pool;
      int    n;
      pool = "0123456789-.eE";
      s = "";
      if ($urandom_range(0, 1) != 0) s = "-";
      s = {s, char_str(8'(32'h30 + $urandom_range(0, 9)))};
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) s = {s, char_str(pool[$urandom_range(0, 13)])};
      return s;
   endfunction

   function automatic string rand_ws();
      string pool;
      pool = " \t\n\r";
      if ($urandom_range(0, 3) == 0) return char_str(pool[$urandom_range(0, 3)]);
      return "";
   endfunction

   function automatic string rand_value(int depth);
      string s;
      int    n;
      int    pick;
      pick = (depth >= 4) ? $urandom_range(0, 5) : $urandom_range(0, 7);
      case (pick)
         0: return "null";
         1: return "true";
         2: return "false";
         3, 4: return {"\"", rand_string_body(), "\""};
         5: return {rand_number(), " "};
         6: begin
            s = "[";
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) s = {s, ","};
               s = {s, rand_ws(), rand_value(depth + 1)};
            end
            return {s, "]"};
         end
         default: begin
            s = "{";
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++) begin
               if (i > 0) s = {s, ","};
               s = {s, "\"", rand_string_body(), "\"", rand_ws(), ":",
                    rand_ws(), rand_value(depth + 1)};
            end
            // Now and then a trailing comma, which the block accepts.
            if (n > 0 && $urandom_range(0, 5) == 0) s = {s, ","};
            return {s, "}"};
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Directed table. The block gets one reset, and errors are sticky, so the
   // table opens one outer array that the random part then fills with
   // elements; kinds typed in are plain to read off.
   // ------------------------------------------------------------------------
   dir_row_type dir_tab[$];

   function automatic void add_row(logic eoi, logic [7:0] c, logic chk = 1'b0,
                                   jst_pkg::ev_kind_type k = jst_pkg::EV_START_ARRAY,
                                   jst_pkg::err_type e = jst_pkg::ERR_NONE);
      dir_row_type r;
      r.eoi = eoi; r.chr = c; r.check_kind = chk; r.kind = k; r.err = e;
      dir_tab.insert(dir_tab.size(), r);
   endfunction

   initial begin
      string text;
      int    rows_total;
      int    stop_at;
      fail_count  = 0;
      table_fails = 0;
      beats_sent  = 0;
      texts_sent  = 0;
      clear_parser();
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = 8'h00;
      req_ch.end_of_input = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Whitespace, the outer bracket, a string with the all-ones and the
      // zero byte and two escapes, then a number closed by a comma.
      add_row(1'b0, 8'h20);
      add_row(1'b0, "[", 1'b1, jst_pkg::EV_START_ARRAY);
      add_row(1'b0, 8'h22);
      add_row(1'b0, 8'hFF, 1'b1, jst_pkg::EV_STR_CHAR);
      add_row(1'b0, 8'h00, 1'b1, jst_pkg::EV_STR_CHAR);
      add_row(1'b0, 8'h5C);
      add_row(1'b0, "n");
      add_row(1'b0, 8'h5C);
      add_row(1'b0, 8'h7F);
      add_row(1'b0, 8'h22, 1'b1, jst_pkg::EV_STR_END);
      add_row(1'b0, ",");
      add_row(1'b0, "-", 1'b1, jst_pkg::EV_NUM_CHAR);
      add_row(1'b0, "9");
      add_row(1'b0, "E");
      add_row(1'b0, ",", 1'b1, jst_pkg::EV_NUM_END);
      rows_total = dir_tab.size();

      for (int i = 0; i < rows_total; i++) begin
         send_beat(dir_tab[i].eoi, dir_tab[i].chr);
         if (dir_tab[i].check_kind) begin
            if (step_events.size() == 0 || step_events[0].kind != dir_tab[i].kind ||
                step_events[0].err != dir_tab[i].err) begin
               table_fails++;
               $display("%0t: table row %0d expected kind %0d err %0d", $time, i,
                        dir_tab[i].kind, dir_tab[i].err);
            end
         end
      end

      // Random part: elements of the outer array, each a random value.
      while (beats_sent < 1150 && !timed_out) begin
         text = rand_value(1);
         send_text(text);
         texts_sent++;
         if (texts_sent == 20) begin
            // Hold off the sender until the pipeline is fully drained.
            wait_drained();
         end
         send_text(",");
      end

      // The run ends with one sticky error: depth overflow, an unsupported
      // unicode escape, or a bad array separator.
      stop_at = $urandom_range(0, 2);
      case (stop_at)
         0: for (int i = 0; i < DEPTH_LIMIT + 1; i++) send_text("[");
         1: send_text("\"\\u12aF");
         default: send_text("[1, 2 x");
      endcase
      // Sticky error: these give nothing, and the end of input neither.
      send_text("]]");
      send_beat(1'b1, 8'h00);

      wait_drained();
      repeat (20) @(posedge clock);
      $display("Sent %0d beats in %0d random values; checked %0d events, %0d errors.",
               beats_sent, texts_sent, events_seen, errors_seen);
      if (fail_count == 0 && table_fails == 0 && expected_events.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
